// ----- src/rtb_pkg.sv -----
`timescale 1ns / 1ps

package rtb_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned RESULT_CAP      = 16;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned OP_W            = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [OP_W-1:0] KIND_FIRE   = 2'd0;
  localparam logic [OP_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [OP_W-1:0] KIND_CANCEL = 2'd2;
  localparam logic [OP_W-1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] duration;
    logic [WORD_W-1:0] remaining;
    logic              rep;
    logic [WORD_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic              ok;
    logic [WORD_W-1:0] new_id;
    logic [WORD_W-1:0] event_target;
    logic [WORD_W-1:0] event_duration;
    logic [WORD_W-1:0] event_elapsed;
    logic [WORD_W-1:0] event_tag;
    logic              last;
  } rsp_t;

endpackage

// ----- src/rtb_req_if.sv -----
`timescale 1ns / 1ps

interface rtb_req_if;
  logic                        valid;
  logic                        ready;
  logic [rtb_pkg::OP_W-1:0]    op;
  logic [rtb_pkg::WORD_W-1:0]  elapsed;
  logic [rtb_pkg::WORD_W-1:0]  duration;
  logic                        repeat_req;
  logic [rtb_pkg::WORD_W-1:0]  tag;
  logic [rtb_pkg::WORD_W-1:0]  target;
  logic [rtb_pkg::WORD_W-1:0]  timer_id;

  modport source (output valid, op, elapsed, duration, repeat_req, tag, target, timer_id,
                  input ready);
  modport sink (input valid, op, elapsed, duration, repeat_req, tag, target, timer_id,
                output ready);
endinterface

// ----- src/rtb_rsp_if.sv -----
`timescale 1ns / 1ps

interface rtb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rtb_pkg::OP_W-1:0]    kind;
  logic                        ok;
  logic [rtb_pkg::WORD_W-1:0]  new_id;
  logic [rtb_pkg::WORD_W-1:0]  event_target;
  logic [rtb_pkg::WORD_W-1:0]  event_duration;
  logic [rtb_pkg::WORD_W-1:0]  event_elapsed;
  logic [rtb_pkg::WORD_W-1:0]  event_tag;
  logic                        last;

  modport source (output valid, kind, ok, new_id, event_target, event_duration,
                  event_elapsed, event_tag, last, input ready);
  modport sink (input valid, kind, ok, new_id, event_target, event_duration,
                event_elapsed, event_tag, last, output ready);
endinterface

// ----- src/repeating_timer_bank_unit.sv -----
`timescale 1ns / 1ps
// Bank of software timers with optional auto-reload, held as a dense table.
// req carries one request: tick, add, cancel by id or clear by target.
// rsp returns results; the final result of a request has last set.
// A tick returns a fire event per expiring timer, at most RESULT_CAP in all
// (none if none fires); add, cancel and clear each return a single reply.
// A tick, cancel or clear examines the table entries in turn through the
// one-read, one-write table memory and its shared subtract/reload adder;
// an entry moved into a freed slot is examined only there, and a cancel
// stops at its first hit, moving the last entry into the freed slot. Add
// writes its entry as the request is accepted and needs no scan.
// req.ready is high only between requests.
// Fire events are held one deep so the last one can be marked; a stalled
// rsp holds the scan when a further event must pass, and the final result
// waits in the output register while the next request is accepted.
// Reset empties the table and sets the next id to 1; no clearing pass.
module repeating_timer_bank_unit #(
  parameter int unsigned TIMER_SLOTS = rtb_pkg::TIMER_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rtb_req_if.sink       req,
  rtb_rsp_if.source     rsp
);

  localparam int unsigned AW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned FCW = $clog2(rtb_pkg::RESULT_CAP + 1);
  localparam int unsigned W   = rtb_pkg::WORD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;

  rtb_pkg::slot_t mem [TIMER_SLOTS];
  rtb_pkg::slot_t rdata;
  rtb_pkg::slot_t wr_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;

  logic [2:0]             state, state_next;
  logic [CW-1:0]          idx, idx_next;
  logic [CW-1:0]          used, used_next;
  logic [W-1:0]           next_id, next_id_next;
  logic [rtb_pkg::OP_W-1:0] op_r, op_r_next;
  logic [W-1:0]           elapsed_r, elapsed_r_next;
  logic [W-1:0]           tgt_r, tgt_r_next;
  logic [W-1:0]           tid_r, tid_r_next;
  logic [W-1:0]           nid_r, nid_r_next;
  logic                   found, found_next;
  logic [AW-1:0]          cur_addr;
  logic                   pend_valid, pend_valid_next;
  rtb_pkg::rsp_t          pend, pend_next;
  logic [FCW-1:0]         fire_cnt, fire_cnt_next;
  logic                   out_valid, out_valid_next;
  rtb_pkg::rsp_t          out_r, out_next;

  logic                   out_free;
  logic [W:0]             diff;
  logic [W:0]             sum;
  logic                   fire;
  logic [W-1:0]           new_rem;
  logic [CW-1:0]          last_pos;
  logic [CW-1:0]          idx_inc;
  logic                   record;
  logic                   stall;
  logic                   drop;
  logic [2:0]             finish;

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.kind           = out_r.kind;
  assign rsp.ok             = out_r.ok;
  assign rsp.new_id         = out_r.new_id;
  assign rsp.event_target   = out_r.event_target;
  assign rsp.event_duration = out_r.event_duration;
  assign rsp.event_elapsed  = out_r.event_elapsed;
  assign rsp.event_tag      = out_r.event_tag;
  assign rsp.last           = out_r.last;

  always_comb begin
    diff    = {1'b0, rdata.remaining} - {1'b0, elapsed_r};
    fire    = diff[W] | (diff == '0);
    sum     = diff + {1'b0, rdata.duration};
    new_rem = fire ? (sum[W] ? rdata.duration : sum[W-1:0]) : diff[W-1:0];
    last_pos = used - CW'(1);
    idx_inc  = idx + CW'(1);
    out_free = !out_valid || rsp.ready;
    record   = (op_r == rtb_pkg::OP_TICK) && fire &&
               (fire_cnt < FCW'(rtb_pkg::RESULT_CAP));
    stall    = record && pend_valid && !out_free;
    drop     = ((op_r == rtb_pkg::OP_TICK) && fire && !rdata.rep) ||
               ((op_r == rtb_pkg::OP_CLEAR) && (rdata.target == tgt_r)) ||
               ((op_r == rtb_pkg::OP_CANCEL) && (rdata.id == tid_r));
    finish   = (op_r == rtb_pkg::OP_TICK) ? S_FLUSH : S_REPLY;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    used_next       = used;
    next_id_next    = next_id;
    op_r_next       = op_r;
    elapsed_r_next  = elapsed_r;
    tgt_r_next      = tgt_r;
    tid_r_next      = tid_r;
    nid_r_next      = nid_r;
    found_next      = found;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    fire_cnt_next   = fire_cnt;
    out_valid_next  = out_valid && !rsp.ready;
    out_next        = out_r;
    wr_en           = 1'b0;
    wr_addr         = idx[AW-1:0];
    wr_data         = rdata;
    rd_addr         = cur_addr;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_r_next       = req.op;
          elapsed_r_next  = req.elapsed;
          tgt_r_next      = req.target;
          tid_r_next      = req.timer_id;
          nid_r_next      = '0;
          idx_next        = '0;
          found_next      = 1'b0;
          fire_cnt_next   = '0;
          pend_valid_next = 1'b0;
          rd_addr         = '0;
          unique case (req.op)
            rtb_pkg::OP_TICK: begin
              state_next = (used == '0) ? S_IDLE : S_SCAN;
            end
            rtb_pkg::OP_ADD: begin
              if (req.duration != '0 && used < CW'(TIMER_SLOTS)) begin
                wr_en            = 1'b1;
                wr_addr          = used[AW-1:0];
                wr_data.id       = next_id;
                wr_data.target   = req.target;
                wr_data.duration = req.duration;
                wr_data.remaining = req.duration;
                wr_data.rep      = req.repeat_req;
                wr_data.tag      = req.tag;
                used_next        = used + CW'(1);
                nid_r_next       = next_id;
                found_next       = 1'b1;
                next_id_next     = (next_id == '1) ? W'(1) : next_id + W'(1);
              end
              state_next = S_REPLY;
            end
            rtb_pkg::OP_CANCEL: begin
              state_next = (used == '0 || req.timer_id == '0) ? S_REPLY : S_SCAN;
            end
            default: begin
              state_next = (used == '0) ? S_REPLY : S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (record) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_next       = pend;
            end
            pend_next.kind           = rtb_pkg::KIND_FIRE;
            pend_next.ok             = 1'b0;
            pend_next.new_id         = '0;
            pend_next.event_target   = rdata.target;
            pend_next.event_duration = rdata.duration;
            pend_next.event_elapsed  = elapsed_r;
            pend_next.event_tag      = rdata.tag;
            pend_next.last           = 1'b0;
            pend_valid_next          = 1'b1;
            fire_cnt_next            = fire_cnt + FCW'(1);
          end
          if (drop) begin
            found_next = 1'b1;
            used_next  = last_pos;
            if (idx < last_pos) begin
              rd_addr    = last_pos[AW-1:0];
              state_next = (op_r == rtb_pkg::OP_CANCEL) ? S_COPY : S_SCAN;
            end else begin
              state_next = finish;
            end
          end else begin
            wr_en = 1'b1;
            if (op_r == rtb_pkg::OP_TICK) begin
              wr_data.remaining = new_rem;
            end
            if (idx_inc < used) begin
              idx_next = idx_inc;
              rd_addr  = idx_inc[AW-1:0];
            end else begin
              state_next = finish;
            end
          end
        end
      end

      S_COPY: begin
        wr_en      = 1'b1;
        state_next = S_REPLY;
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_next        = pend;
          out_next.last   = 1'b1;
          out_valid_next  = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          out_next        = '0;
          out_next.kind   = op_r;
          out_next.ok     = found;
          out_next.new_id = nid_r;
          out_next.last   = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      next_id    <= W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      fire_cnt   <= '0;
    end else begin
      state      <= state_next;
      used       <= used_next;
      next_id    <= next_id_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      fire_cnt   <= fire_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    op_r      <= op_r_next;
    elapsed_r <= elapsed_r_next;
    tgt_r     <= tgt_r_next;
    tid_r     <= tid_r_next;
    nid_r     <= nid_r_next;
    found     <= found_next;
    cur_addr  <= rd_addr;
    pend      <= pend_next;
    out_r     <= out_next;
  end

endmodule

// ----- test/repeating_timer_bank_unit_tb.sv -----
`timescale 1ns / 1ps

module repeating_timer_bank_unit_tb;

  localparam int unsigned WORD_W = rtb_pkg::WORD_W;
  localparam int unsigned OP_W = rtb_pkg::OP_W;
  localparam int unsigned BANK_SLOTS = rtb_pkg::TIMER_SLOTS_DEF;
  localparam int unsigned RANDOM_REQUESTS = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] elapsed;
    logic [WORD_W-1:0] duration;
    logic              rep;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] timer_id;
    bit                typed;
    logic              typed_ok;
    logic [WORD_W-1:0] typed_id;
  } timer_req_t;

  logic clk;
  logic rst;

  rtb_req_if req ();
  rtb_rsp_if rsp ();

  repeating_timer_bank_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [WORD_W-1:0] tbl_id       [];
  logic [WORD_W-1:0] tbl_target   [];
  logic [WORD_W-1:0] tbl_duration [];
  logic [WORD_W-1:0] tbl_tag      [];
  longint            tbl_left     [];
  bit                tbl_reload   [];
  int unsigned       live_count;
  logic [WORD_W-1:0] id_counter;

  rtb_pkg::rsp_t step_results [$];
  rtb_pkg::rsp_t timer_results_due [$];
  timer_req_t    directed [$];

  int mismatches;
  int req_gap_pct;
  int rsp_gap_pct;
  bit rsp_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic add_row(input timer_req_t rq);
    directed.insert(directed.size(), rq);
  endtask

  task automatic note_step(input rtb_pkg::rsp_t r);
    step_results.insert(step_results.size(), r);
  endtask

  task automatic note_due(input rtb_pkg::rsp_t r);
    timer_results_due.insert(timer_results_due.size(), r);
  endtask

  task automatic retire_slot(input int unsigned idx);
    int unsigned tail;
    tail = live_count - 1;
    tbl_id[idx]       = tbl_id[tail];
    tbl_target[idx]   = tbl_target[tail];
    tbl_duration[idx] = tbl_duration[tail];
    tbl_tag[idx]      = tbl_tag[tail];
    tbl_left[idx]     = tbl_left[tail];
    tbl_reload[idx]   = tbl_reload[tail];
    live_count        = tail;
  endtask

  task automatic apply_timer_request(input timer_req_t rq);
    int unsigned   i;
    int unsigned   fired;
    longint        left;
    logic          hit;
    rtb_pkg::rsp_t r;
    step_results.delete();
    i     = 0;
    fired = 0;
    hit   = 1'b0;
    r     = '0;
    case (rq.op)
      rtb_pkg::OP_TICK: begin
        while (i < live_count) begin
          left = tbl_left[i] - longint'({32'd0, rq.elapsed});
          tbl_left[i] = left;
          if (left <= 0) begin
            if (fired < rtb_pkg::RESULT_CAP) begin
              r                = '0;
              r.kind           = rtb_pkg::KIND_FIRE;
              r.event_target   = tbl_target[i];
              r.event_duration = tbl_duration[i];
              r.event_elapsed  = rq.elapsed;
              r.event_tag      = tbl_tag[i];
              note_step(r);
              fired++;
            end
            if (tbl_reload[i]) begin
              left = left + longint'({32'd0, tbl_duration[i]});
              if (left < 0) left = longint'({32'd0, tbl_duration[i]});
              tbl_left[i] = left;
              i++;
            end else begin
              retire_slot(i);
            end
          end else begin
            i++;
          end
        end
      end
      rtb_pkg::OP_ADD: begin
        r.kind = rtb_pkg::KIND_ADD;
        if (rq.duration != '0 && live_count < BANK_SLOTS) begin
          tbl_id[live_count]       = id_counter;
          tbl_target[live_count]   = rq.target;
          tbl_duration[live_count] = rq.duration;
          tbl_tag[live_count]      = rq.tag;
          tbl_left[live_count]     = longint'({32'd0, rq.duration});
          tbl_reload[live_count]   = rq.rep;
          live_count++;
          r.ok     = 1'b1;
          r.new_id = id_counter;
          id_counter = id_counter + WORD_W'(1);
          if (id_counter == '0) id_counter = WORD_W'(1);
        end
        note_step(r);
      end
      rtb_pkg::OP_CANCEL: begin
        r.kind = rtb_pkg::KIND_CANCEL;
        if (rq.timer_id != '0) begin
          while (i < live_count && !hit) begin
            if (tbl_id[i] == rq.timer_id) begin
              retire_slot(i);
              hit = 1'b1;
            end else begin
              i++;
            end
          end
        end
        r.ok = hit;
        note_step(r);
      end
      default: begin
        r.kind = rtb_pkg::KIND_CLEAR;
        while (i < live_count) begin
          if (tbl_target[i] == rq.target) begin
            retire_slot(i);
            hit = 1'b1;
          end else begin
            i++;
          end
        end
        r.ok = hit;
        note_step(r);
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
  endtask

  function automatic timer_req_t req_row(input logic [OP_W-1:0] op,
                                         input logic [WORD_W-1:0] elapsed,
                                         input logic [WORD_W-1:0] duration,
                                         input logic rep,
                                         input logic [WORD_W-1:0] tag,
                                         input logic [WORD_W-1:0] target,
                                         input logic [WORD_W-1:0] timer_id,
                                         input bit typed,
                                         input logic typed_ok,
                                         input logic [WORD_W-1:0] typed_id);
    timer_req_t rq;
    rq.op       = op;
    rq.elapsed  = elapsed;
    rq.duration = duration;
    rq.rep      = rep;
    rq.tag      = tag;
    rq.target   = target;
    rq.timer_id = timer_id;
    rq.typed    = typed;
    rq.typed_ok = typed_ok;
    rq.typed_id = typed_id;
    return rq;
  endfunction

  function automatic timer_req_t draw_timer_req(input bit add_only);
    timer_req_t rq;
    int unsigned pick;
    rq.op       = rtb_pkg::OP_TICK;
    rq.elapsed  = $urandom;
    rq.duration = $urandom;
    rq.rep      = 1'($urandom_range(1, 0));
    rq.tag      = $urandom;
    rq.target   = $urandom;
    rq.timer_id = $urandom;
    rq.typed    = 1'b0;
    rq.typed_ok = 1'b0;
    rq.typed_id = '0;
    pick = add_only ? 50 : $urandom_range(99);
    if (pick < 40) begin
      rq.op = rtb_pkg::OP_TICK;
      pick = $urandom_range(99);
      if (pick < 10) rq.elapsed = '0;
      else if (pick >= 20) rq.elapsed = $urandom_range(8, 1);
    end else if (pick < 70) begin
      rq.op = rtb_pkg::OP_ADD;
      pick = $urandom_range(99);
      if (pick < 5 && !add_only) rq.duration = '0;
      else if (pick >= 15) rq.duration = $urandom_range(12, 1);
      else if (rq.duration == '0) rq.duration = WORD_W'(1);
      if ($urandom_range(99) < 80) rq.target = $urandom_range(3, 0);
    end else if (pick < 85) begin
      rq.op = rtb_pkg::OP_CANCEL;
      pick = $urandom_range(99);
      if (live_count > 0 && pick < 70) rq.timer_id = tbl_id[$urandom_range(live_count-1, 0)];
      else if (pick < 80) rq.timer_id = '0;
    end else begin
      rq.op = rtb_pkg::OP_CLEAR;
      pick = $urandom_range(99);
      if (live_count > 0 && pick < 50) rq.target = tbl_target[$urandom_range(live_count-1, 0)];
      else if (pick < 85) rq.target = $urandom_range(3, 0);
    end
    return rq;
  endfunction

  task automatic offer_request(input timer_req_t rq);
    rtb_pkg::rsp_t r;
    @(negedge clk);
    while ($urandom_range(99) < req_gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.op         <= rq.op;
    req.elapsed    <= rq.elapsed;
    req.duration   <= rq.duration;
    req.repeat_req <= rq.rep;
    req.tag        <= rq.tag;
    req.target     <= rq.target;
    req.timer_id   <= rq.timer_id;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    apply_timer_request(rq);
    if (rq.typed) begin
      r        = '0;
      r.kind   = rq.op;
      r.ok     = rq.typed_ok;
      r.new_id = rq.typed_id;
      r.last   = 1'b1;
      note_due(r);
    end else begin
      foreach (step_results[k]) note_due(step_results[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    rtb_pkg::rsp_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (timer_results_due.size() == 0) begin
        $error("result with nothing outstanding: kind %0d", rsp.kind);
        mismatches++;
      end else begin
        want = timer_results_due.pop_front();
        check_field("kind", WORD_W'(want.kind), WORD_W'(rsp.kind));
        check_field("ok", WORD_W'(want.ok), WORD_W'(rsp.ok));
        check_field("new_id", want.new_id, rsp.new_id);
        check_field("event_target", want.event_target, rsp.event_target);
        check_field("event_duration", want.event_duration, rsp.event_duration);
        check_field("event_elapsed", want.event_elapsed, rsp.event_elapsed);
        check_field("event_tag", want.event_tag, rsp.event_tag);
        check_field("last", WORD_W'(want.last), WORD_W'(rsp.last));
      end
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req && !hold_done) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
    end
  end

  initial begin
    int unsigned sent_random;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.op         = rtb_pkg::OP_TICK;
    req.elapsed    = '0;
    req.duration   = '0;
    req.repeat_req = 1'b0;
    req.tag        = '0;
    req.target     = '0;
    req.timer_id   = '0;
    mismatches     = 0;
    req_gap_pct    = 11;
    rsp_gap_pct    = 11;
    rsp_hold_req   = 1'b0;
    live_count     = 0;
    id_counter     = WORD_W'(1);
    sent_random    = 0;
    tbl_id         = new[BANK_SLOTS];
    tbl_target     = new[BANK_SLOTS];
    tbl_duration   = new[BANK_SLOTS];
    tbl_tag        = new[BANK_SLOTS];
    tbl_left       = new[BANK_SLOTS];
    tbl_reload     = new[BANK_SLOTS];

    //      op                  elapsed       duration      rep   tag           target
    //      timer_id            typed ok   id
    add_row(req_row(rtb_pkg::OP_TICK,   32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CANCEL, 32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CLEAR,  32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd0,        1'b1, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'd0,        1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd1,        1'b0, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'd0,        1'b1, 1'b1, 32'd1));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'hFFFFFFFF, 1'b1, 32'd0,        32'd0,
                    32'd0,        1'b1, 1'b1, 32'd2));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd5,        1'b1, 32'h5A5A5A5A, 32'd7,
                    32'd0,        1'b1, 1'b1, 32'd3));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd3,        1'b0, 32'hA5A5A5A5, 32'd7,
                    32'd0,        1'b1, 1'b1, 32'd4));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd2,        1'b1, 32'd1,        32'd7,
                    32'd0,        1'b1, 1'b1, 32'd5));
    add_row(req_row(rtb_pkg::OP_TICK,   32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_TICK,   32'd1,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_TICK,   32'd2,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_TICK,   32'hFFFFFFFF, 32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CANCEL, 32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'hFFFFFFFF, 1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CANCEL, 32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd1000,     1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CANCEL, 32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd2,        1'b1, 1'b1, 32'd0));
    add_row(req_row(rtb_pkg::OP_CLEAR,  32'd0,        32'd0,        1'b0, 32'd0,        32'd7,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CLEAR,  32'd0,        32'd0,        1'b0, 32'd0,        32'd7,
                    32'd0,        1'b1, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd4,        1'b0, 32'hDEADBEEF, 32'd3,
                    32'd0,        1'b1, 1'b1, 32'd6));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd4,        1'b0, 32'h12345678, 32'd3,
                    32'd0,        1'b1, 1'b1, 32'd7));
    add_row(req_row(rtb_pkg::OP_ADD,    32'd0,        32'd4,        1'b1, 32'h0F0F0F0F, 32'd9,
                    32'd0,        1'b1, 1'b1, 32'd8));
    add_row(req_row(rtb_pkg::OP_TICK,   32'd4,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_TICK,   32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd0,        1'b0, 1'b0, 32'd0));
    add_row(req_row(rtb_pkg::OP_CANCEL, 32'd0,        32'd0,        1'b0, 32'd0,        32'd0,
                    32'd8,        1'b1, 1'b1, 32'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[n]) offer_request(directed[n]);

    while (sent_random < RANDOM_REQUESTS) begin
      if (sent_random >= 180 && sent_random < 260) begin
        req_gap_pct = 0;
        rsp_gap_pct = 0;
      end else begin
        req_gap_pct = 11;
        rsp_gap_pct = 11;
      end
      if (sent_random >= 100) rsp_hold_req = 1'b1;
      if ($urandom_range(99) < 6) begin
        // fill the bank, then push one more add against the full table
        while (live_count < BANK_SLOTS) begin
          offer_request(draw_timer_req(1'b1));
          sent_random++;
        end
        offer_request(draw_timer_req(1'b1));
      end else begin
        offer_request(draw_timer_req(1'b0));
      end
      sent_random++;
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && timer_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
